@@ design/bdhr_pkg.sv @@
// Package for the button debouncer with hold and auto-repeat.
// Holds register indexes, reset values and the state, config and result types.
// Used by every module of the block; depends on nothing.
package bdhr_pkg;

  localparam int unsigned DebW    = 4;
  localparam int unsigned HeldW   = 10;
  localparam int unsigned RepW    = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [DebW-1:0]  DebMax  = '1;
  localparam logic [HeldW-1:0] HeldMax = '1;
  localparam logic [RepW-1:0]  RepMax  = '1;

  localparam logic [CfgIdxW-1:0] RegDebounceTicks = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHoldTicks     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRepeatDelay   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRepeatPeriod  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHoldEnable    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRepeatEnable  = 3'd5;

  localparam logic [DebW-1:0]  RstDebounceTicks = 4'd3;
  localparam logic [HeldW-1:0] RstHoldTicks     = 10'd50;
  localparam logic [HeldW-1:0] RstRepeatDelay   = 10'd40;
  localparam logic [RepW-1:0]  RstRepeatPeriod  = 8'd12;

  // Button levels are active low.
  localparam logic LevelPressed  = 1'b0;
  localparam logic LevelReleased = 1'b1;

  typedef struct packed {
    logic [DebW-1:0]  debounce_ticks;
    logic [HeldW-1:0] hold_ticks;
    logic [HeldW-1:0] repeat_delay_ticks;
    logic [RepW-1:0]  repeat_period_ticks;
    logic             hold_enable;
    logic             repeat_enable;
  } cfg_t;

  typedef struct packed {
    logic             last_level;
    logic             settled_level;
    logic [DebW-1:0]  debounce_count;
    logic [HeldW-1:0] held_count;
    logic [RepW-1:0]  repeat_count;
    logic             hold_done;
  } state_t;

  typedef struct packed {
    logic short_pulse;
    logic hold_pulse;
    logic debounced_level;
  } result_t;

endpackage

@@ design/bdhr_cfg.sv @@
// Configuration register file of the button debouncer.
// Six write-only registers behind a plain write port; uses bdhr_pkg.
module bdhr_cfg
  import bdhr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks      <= RstDebounceTicks;
      cfg.hold_ticks          <= RstHoldTicks;
      cfg.repeat_delay_ticks  <= RstRepeatDelay;
      cfg.repeat_period_ticks <= RstRepeatPeriod;
      cfg.hold_enable         <= 1'b0;
      cfg.repeat_enable       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        RegDebounceTicks: cfg.debounce_ticks      <= cfg_data[DebW-1:0];
        RegHoldTicks:     cfg.hold_ticks          <= cfg_data[HeldW-1:0];
        RegRepeatDelay:   cfg.repeat_delay_ticks  <= cfg_data[HeldW-1:0];
        RegRepeatPeriod:  cfg.repeat_period_ticks <= cfg_data[RepW-1:0];
        RegHoldEnable:    cfg.hold_enable         <= cfg_data[0];
        RegRepeatEnable:  cfg.repeat_enable       <= cfg_data[0];
        default: begin
          // Unused indexes are ignored.
        end
      endcase
    end
  end

endmodule

@@ design/bdhr_step.sv @@
// Combinational tick update of the button debouncer.
// Takes the current state, config and one level sample; uses bdhr_pkg.
module bdhr_step
  import bdhr_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  state,
  input  logic    level,
  output state_t  state_next,
  output result_t result
);

  always_comb begin
    logic [DebW-1:0] thr;
    logic            short_ev;
    logic            hold_ev;
    state_t          s;

    s        = state;
    short_ev = 1'b0;
    hold_ev  = 1'b0;
    // A debounce length of zero behaves as one.
    thr = (cfg.debounce_ticks == '0) ? {{(DebW-1){1'b0}}, 1'b1} : cfg.debounce_ticks;

    if (level != s.last_level) begin
      s.last_level     = level;
      s.debounce_count = '0;
    end else begin
      if (s.debounce_count < thr && s.debounce_count != DebMax) begin
        s.debounce_count = s.debounce_count + 1'b1;
      end
      if (s.debounce_count >= thr && s.settled_level != s.last_level) begin
        s.settled_level = s.last_level;
        if (s.settled_level == LevelPressed) begin
          short_ev = !cfg.hold_enable;
        end else begin
          short_ev = cfg.hold_enable && !s.hold_done;
        end
        s.held_count   = '0;
        s.repeat_count = '0;
        s.hold_done    = 1'b0;
      end
    end

    if (s.last_level == LevelPressed && s.settled_level == LevelPressed) begin
      if (s.held_count != HeldMax) begin
        s.held_count = s.held_count + 1'b1;
      end
      if (cfg.hold_enable && !s.hold_done && s.held_count >= cfg.hold_ticks) begin
        s.hold_done = 1'b1;
        hold_ev     = 1'b1;
      end
      if (cfg.repeat_enable && s.held_count >= cfg.repeat_delay_ticks) begin
        if (s.repeat_count != RepMax) begin
          s.repeat_count = s.repeat_count + 1'b1;
        end
        if (s.repeat_count >= cfg.repeat_period_ticks) begin
          s.repeat_count = '0;
          short_ev       = 1'b1;
        end
      end
    end

    state_next             = s;
    result.short_pulse     = short_ev;
    result.hold_pulse      = hold_ev;
    result.debounced_level = s.settled_level;
  end

endmodule

@@ design/button_debounce_hold_repeat.sv @@
// Top level of the button debouncer with hold and auto-repeat events.
// Instantiates bdhr_cfg and bdhr_step; uses bdhr_pkg.
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid / in_ready    level_in
//   output    out        out_valid / out_ready  short_pulse, hold_pulse, debounced_level
//   config    in         cfg_write              cfg_index, cfg_data
//
// Each input word is captured in an input register; when it moves on, the tick
// update runs through one level of short compare and count logic into the
// result register while the debounce state registers advance together.
// A word accepted into the input register is loaded into the result register
// as it moves on, and is offered from there until it is taken; one word is
// taken every cycle while the output side keeps accepting.
// When the result register is full and not being taken, the input register
// holds its word; new words are still accepted until that register fills too.
// Synchronous reset returns both levels to released, clears all counters and
// flags, empties both registers and loads the default configuration.
module button_debounce_hold_repeat
  import bdhr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                level_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                short_pulse,
  output logic                hold_pulse,
  output logic                debounced_level,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  result_t result_next;

  logic s1_valid;
  logic s1_level;
  logic s1_advance;

  bdhr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdhr_step u_step (
    .cfg        (cfg),
    .state      (state),
    .level      (s1_level),
    .state_next (state_next),
    .result     (result_next)
  );

  // The captured word moves on when the result register is empty or is
  // being emptied this cycle.
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_level <= level_in;
    end
  end

  // Debounce state only advances when a word leaves the input register, so
  // stalls never repeat or skip a tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.last_level     <= LevelReleased;
      state.settled_level  <= LevelReleased;
      state.debounce_count <= '0;
      state.held_count     <= '0;
      state.repeat_count   <= '0;
      state.hold_done      <= 1'b0;
    end else if (s1_advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      short_pulse     <= result_next.short_pulse;
      hold_pulse      <= result_next.hold_pulse;
      debounced_level <= result_next.debounced_level;
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for button_debounce_hold_repeat.
// Drives level words and register writes, and predicts every result word in SV.
// Depends only on bdhr_pkg and the block itself.
module tb_top;
  import bdhr_pkg::*;

  // Index values that no register answers to; writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] RegUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = 3'd7;

  // The run is stopped as failed if it ever gets this far.
  localparam int unsigned CycleLimit = 300_000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                level_in = LevelReleased;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                short_pulse;
  logic                hold_pulse;
  logic                debounced_level;
  logic                cfg_write = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  button_debounce_hold_repeat dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .level_in        (level_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .short_pulse     (short_pulse),
    .hold_pulse      (hold_pulse),
    .debounced_level (debounced_level),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Our own copy of the configuration and the debouncer state, advanced once
  // per accepted level word.
  cfg_t   cfg_model = '{debounce_ticks: RstDebounceTicks, hold_ticks: RstHoldTicks,
                        repeat_delay_ticks: RstRepeatDelay,
                        repeat_period_ticks: RstRepeatPeriod,
                        hold_enable: 1'b0, repeat_enable: 1'b0};
  state_t btn_state = '{last_level: LevelReleased, settled_level: LevelReleased,
                        debounce_count: '0, held_count: '0, repeat_count: '0,
                        hold_done: 1'b0};

  logic        level_words[$];       // levels waiting to be sent
  result_t     predicted_words[$];   // results the block still owes us
  int unsigned levels_queued = 0;
  int unsigned levels_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  logic        in_fire = 1'b0;       // a level word was taken at the last rising edge
  logic        out_fire = 1'b0;      // a result word was taken at the last rising edge
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned calm_left[2] = '{0, 0};
  result_t     want;
  result_t     got;

  // One poll tick of the debouncer. The debounce stage runs first; a newly
  // stable level clears the hold and repeat bookkeeping. Only then does a held
  // press count up and test for the hold event and for auto-repeat.
  function automatic result_t debounce_tick(input logic level);
    result_t     res;
    int unsigned thr;
    res = '0;
    // A debounce length of zero behaves like one.
    thr = (cfg_model.debounce_ticks == '0) ? 1 : cfg_model.debounce_ticks;
    if (level != btn_state.last_level) begin
      btn_state.last_level = level;
      btn_state.debounce_count = '0;
    end else begin
      if (btn_state.debounce_count < thr && btn_state.debounce_count < DebMax)
        btn_state.debounce_count = btn_state.debounce_count + 1'b1;
      // If the length was lowered while counting, the count may already be
      // past the threshold, and the new level is taken at once.
      if (btn_state.debounce_count >= thr &&
          btn_state.settled_level != btn_state.last_level) begin
        btn_state.settled_level = btn_state.last_level;
        if (btn_state.settled_level == LevelPressed) begin
          if (!cfg_model.hold_enable) res.short_pulse = 1'b1;
        end else if (cfg_model.hold_enable && !btn_state.hold_done) begin
          res.short_pulse = 1'b1;
        end
        btn_state.held_count = '0;
        btn_state.repeat_count = '0;
        btn_state.hold_done = 1'b0;
      end
    end
    if (btn_state.last_level == btn_state.settled_level &&
        btn_state.settled_level == LevelPressed) begin
      if (btn_state.held_count < HeldMax)
        btn_state.held_count = btn_state.held_count + 1'b1;
      if (cfg_model.hold_enable && !btn_state.hold_done &&
          btn_state.held_count >= cfg_model.hold_ticks) begin
        btn_state.hold_done = 1'b1;
        res.hold_pulse = 1'b1;
      end
      if (cfg_model.repeat_enable &&
          btn_state.held_count >= cfg_model.repeat_delay_ticks) begin
        if (btn_state.repeat_count < RepMax)
          btn_state.repeat_count = btn_state.repeat_count + 1'b1;
        // A press and a repeat on the same tick still give one short pulse.
        if (btn_state.repeat_count >= cfg_model.repeat_period_ticks) begin
          btn_state.repeat_count = '0;
          res.short_pulse = 1'b1;
        end
      end
    end
    res.debounced_level = btn_state.settled_level;
    return res;
  endfunction

  // Idle lengths for either side: mostly none or short, a few long, and now
  // and then a calm stretch of many words with no idling at all.
  function automatic int unsigned gap_len(input int side);
    int unsigned r;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left[side] = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Driver: new words are presented at the falling edge. A word stays on the
  // port until the monitor has seen it taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (level_words.size() != 0) begin
          in_valid <= 1'b1;
          level_in <= level_words.pop_front();
          send_gap = gap_len(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
      // The result side stalls for a random spell after a taken word.
      if (recv_stall > 0) begin
        out_ready <= 1'b0;
        recv_stall--;
      end else begin
        out_ready <= 1'b1;
        if (out_fire) recv_stall = gap_len(1);
      end
    end
  end

  // Monitor: both handshakes are sampled at the rising edge. A taken level
  // word is run through the predictor right away, and a taken result word is
  // checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      out_fire <= out_valid && out_ready;
      if (in_valid && in_ready) begin
        predicted_words.push_back(debounce_tick(level_in));
        levels_taken++;
      end
      if (out_valid && out_ready) begin
        got = {short_pulse, hold_pulse, debounced_level};
        if (predicted_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with none predicted: short %b hold %b level %b",
                     $time, got.short_pulse, got.hold_pulse, got.debounced_level);
        end else begin
          want = predicted_words.pop_front();
          if (got.short_pulse !== want.short_pulse || got.hold_pulse !== want.hold_pulse ||
              got.debounced_level !== want.debounced_level) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch: short %b/%b hold %b/%b level %b/%b (exp/got)",
                       $time, want.short_pulse, got.short_pulse, want.hold_pulse,
                       got.hold_pulse, want.debounced_level, got.debounced_level);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_levels(input logic lvl, input int unsigned n);
    repeat (n) level_words.push_back(lvl);
    levels_queued += n;
  endtask

  // Writes one register. Bits above the register's width carry random junk,
  // which the block must drop, and unused indexes must be ignored entirely.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    logic [CfgDataW-1:0] data;
    data = val;
    case (idx)
      RegDebounceTicks: begin
        data[CfgDataW-1:DebW] = (CfgDataW-DebW)'($urandom);
        cfg_model.debounce_ticks = data[DebW-1:0];
      end
      RegHoldTicks:    cfg_model.hold_ticks = data;
      RegRepeatDelay:  cfg_model.repeat_delay_ticks = data;
      RegRepeatPeriod: begin
        data[CfgDataW-1:RepW] = (CfgDataW-RepW)'($urandom);
        cfg_model.repeat_period_ticks = data[RepW-1:0];
      end
      RegHoldEnable: begin
        data[CfgDataW-1:1] = (CfgDataW-1)'($urandom);
        cfg_model.hold_enable = data[0];
      end
      RegRepeatEnable: begin
        data[CfgDataW-1:1] = (CfgDataW-1)'($urandom);
        cfg_model.repeat_enable = data[0];
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_regs(input logic [DebW-1:0] deb, input logic [HeldW-1:0] hold,
                          input logic [HeldW-1:0] delay, input logic [RepW-1:0] period,
                          input logic hen, input logic ren);
    write_reg(RegDebounceTicks, CfgDataW'(deb));
    write_reg(RegHoldTicks, hold);
    write_reg(RegRepeatDelay, delay);
    write_reg(RegRepeatPeriod, CfgDataW'(period));
    write_reg(RegHoldEnable, CfgDataW'(hen));
    write_reg(RegRepeatEnable, CfgDataW'(ren));
  endtask

  // Waits until every queued level has been taken and every predicted result
  // has come back, so registers can be written safely.
  task automatic drain();
    while (levels_taken != levels_queued || predicted_words.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Contact bounce: a few flickers toward a level, each too short to pass the
  // debounce filter.
  task automatic push_bounce(input logic toward, input int unsigned thr);
    repeat ($urandom_range(0, 3)) begin
      push_levels(toward, $urandom_range(1, thr));
      push_levels(!toward, $urandom_range(1, thr));
    end
  endtask

  // One random phase under the current settings. Most of it is full presses:
  // bounce, a held press of random length, bounce, a released spell. The rest
  // is random noise. The phase ends with a random run of one level, which can
  // leave the next settings to start with a debounce count in progress.
  task automatic run_phase(input int unsigned target, input int unsigned press_max);
    int unsigned start;
    int unsigned thr;
    start = levels_queued;
    thr = (cfg_model.debounce_ticks == '0) ? 1 : cfg_model.debounce_ticks;
    while (levels_queued - start < target) begin
      if ($urandom_range(0, 9) < 2) begin
        repeat ($urandom_range(1, 12)) push_levels(1'($urandom_range(0, 1)), 1);
      end else begin
        push_bounce(LevelPressed, thr);
        push_levels(LevelPressed, $urandom_range(1, press_max));
        push_bounce(LevelReleased, thr);
        push_levels(LevelReleased, $urandom_range(1, 2 * thr + 6));
      end
    end
    push_levels(1'($urandom_range(0, 1)), $urandom_range(0, 14));
    drain();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: a glitch too short to count, a
    // clean press that gives a short pulse, a glitch while pressed, a release.
    push_levels(LevelReleased, 1);
    push_levels(LevelPressed, 1);
    push_levels(LevelReleased, 1);
    push_levels(LevelPressed, 5);
    push_levels(LevelReleased, 2);
    push_levels(LevelPressed, 1);
    push_levels(LevelReleased, 5);
    drain();

    // Writes to unused indexes must leave the settings alone.
    write_reg(RegUnusedLo, '1);
    write_reg(RegUnusedHi, CfgDataW'($urandom));

    // Zero debounce, hold and period, repeat with no delay: the press tick
    // carries both the press event and a repeat, and repeats fire every tick.
    set_regs('0, '0, '0, '0, 1'b0, 1'b1);
    push_levels(LevelPressed, 4);
    push_levels(LevelReleased, 3);
    drain();

    // Random phases over a spread of settings, extremes included.
    set_regs(4'd2, 10'd8, 10'd5, 8'd3, 1'b1, 1'b1);
    run_phase(45, 25);
    set_regs(4'd1, 10'd4, 10'd0, 8'd1, 1'b0, 1'b1);
    run_phase(35, 15);
    set_regs(4'd0, 10'd0, 10'd2, 8'd0, 1'b1, 1'b1);
    run_phase(30, 10);
    set_regs(4'd5, 10'd20, 10'd10, 8'd4, 1'b1, 1'b0);
    run_phase(35, 40);
    set_regs(RstDebounceTicks, RstHoldTicks, RstRepeatDelay, RstRepeatPeriod, 1'b0, 1'b0);
    run_phase(35, 60);

    // Largest register values: the longest debounce, with hold and repeat set
    // too far off to fire within these presses.
    set_regs(4'd15, 10'd1023, 10'd1023, 8'd255, 1'b1, 1'b1);
    run_phase(20, 40);

    set_regs(4'd7, 10'd12, 10'd6, 8'd5, 1'b0, 1'b1);
    run_phase(25, 35);

    repeat (6) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
